>>> design/fft_butterfly_plan_generator_top_defines.svh
// assertion macros for the fft butterfly plan generator
// used by the top level; no other dependencies
`ifndef FFT_BUTTERFLY_PLAN_GENERATOR_TOP_DEFINES_SVH
`define FFT_BUTTERFLY_PLAN_GENERATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FBPG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbpg assertion failed");
// next-cycle implication
`define FBPG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbpg assertion failed");
`else
`define FBPG_ASSERT_IMP(label, clk, rst, ante, cons)
`define FBPG_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/fbpg_pkg.sv
// shared types, constants and the quarter-wave cosine table
// no dependencies
`default_nettype none

package fbpg_pkg;

   localparam int LOG2_MAX     = 10;
   localparam int TWIDDLE_BITS = 16;
   localparam int STAGE_W      = 4;
   localparam int POS_W        = 10;
   localparam int SIZE_W       = 4;
   localparam int TW_W         = 16;

   // table entries are unsigned magnitudes with TWIDDLE_BITS-1 fraction bits
   localparam int CW            = TWIDDLE_BITS - 1;
   // finest twiddle step is 2^(LOG2_MAX+1-(LOG2_MAX-1)) = 4 quarter-wave units
   localparam int TBL_STEP_LOG2 = 2;
   localparam int TBL_ENTRIES   = (1 << (LOG2_MAX - TBL_STEP_LOG2)) + 1;
   localparam int TBL_IDX_W     = $clog2(TBL_ENTRIES);
   localparam int ARG_W         = LOG2_MAX + 2;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

   typedef struct packed {
      logic [STAGE_W-1:0] stage_number;
      logic [POS_W-1:0]   position;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]        read_index_a;
      logic [POS_W-1:0]        read_index_b;
      logic signed [TW_W-1:0]  twiddle_real;
      logic signed [TW_W-1:0]  twiddle_imag;
      logic                    in_range;
   } result_type;

   // elaboration-time taylor series of cos over the quarter wave, q30 fixed point
   function automatic logic [TBL_ENTRIES*CW-1:0] build_cos_table();
      logic [TBL_ENTRIES*CW-1:0] tbl;
      longint unsigned half_pi;
      longint unsigned x;
      longint unsigned term;
      longint unsigned m;
      longint          acc;
      longint          v;
      longint          maxv;
      int              i;
      int              n;
      tbl     = '0;
      half_pi = (PI_Q60 >> 30) >> 1;
      maxv    = (64'sd1 <<< CW) - 64'sd1;
      for (i = 0; i < TBL_ENTRIES; i++) begin
         m    = 64'(i) << TBL_STEP_LOG2;
         x    = (half_pi * m) >> LOG2_MAX;
         term = 64'd1 << 30;
         acc  = 64'sd1 <<< 30;
         for (n = 1; n <= 10; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n - 1) * (2 * n));
            if ((n & 1) != 0) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) acc = 0;
         if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
         v = (acc + (64'sd1 <<< (29 - CW))) >>> (30 - CW);
         if (v > maxv) v = maxv;
         tbl[i*CW +: CW] = CW'(v);
      end
      return tbl;
   endfunction

   localparam logic [TBL_ENTRIES*CW-1:0] COS_TABLE = build_cos_table();

   function automatic logic [CW-1:0] cos_lookup(input logic [TBL_IDX_W-1:0] idx);
      return COS_TABLE[idx*CW +: CW];
   endfunction

   // full-width bit reversal
   function automatic logic [POS_W-1:0] rev_bits(input logic [POS_W-1:0] v);
      logic [POS_W-1:0] r;
      for (int i = 0; i < POS_W; i++) begin
         r[i] = v[POS_W-1-i];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/fft_butterfly_plan_generator_top.sv
// Radix-2 FFT butterfly plan generator: read indices and twiddle per request.
// Request channel (req_*): stage number and output position, valid/stall.
// Result channel (rsp_*): both read indices, Q1.15 twiddle and an in_range
// flag; a request outside the configured size returns all zeros.
// Configuration: csr_write_enable/csr_write_data set log2_size; the user must write it
// only while no transfer is in flight (not enforced here); reset value is 10 (1024 points).
// Pipeline: a request passes through the input register, then the result
// register, before its result can transfer; throughput one transfer per cycle
// while rsp_stall is low, set by the single pass through the index logic and
// the two cosine table reads.
// Reset clears both valid flags and restores log2_size; nothing else needs
// clearing. When the receiver stalls, the result register holds and the
// input register fills; req_stall rises only once both are occupied and
// rsp_stall is high, so no transfer is ever lost or repeated.
// depends on fbpg_pkg, fbpg_calc and the assertion macro header
`default_nettype none
`include "fft_butterfly_plan_generator_top_defines.svh"

module fft_butterfly_plan_generator_top
   import fbpg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [STAGE_W-1:0]     req_stage_number,
   input  wire logic [POS_W-1:0]       req_position,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [POS_W-1:0]       rsp_read_index_a,
   output      logic [POS_W-1:0]       rsp_read_index_b,
   output      logic signed [TW_W-1:0] rsp_twiddle_real,
   output      logic signed [TW_W-1:0] rsp_twiddle_imag,
   output      logic                   rsp_in_range,
   input  wire logic                   csr_write_enable,
   input  wire logic [SIZE_W-1:0]      csr_write_data
);

   logic [SIZE_W-1:0] log2_size_ff, log2_size_in;
   logic              s1_valid_ff, s1_valid_in;
   req_type           s1_req_ff, s1_req_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;
   result_type        calc_result;
   logic              adv_out;
   logic              adv_in;
   req_type           req_bus;
   logic              rsp_live;

   // pipeline advance conditions
   assign adv_out   = !rsp_valid_ff || !rsp_stall;
   assign adv_in    = !s1_valid_ff || adv_out;
   assign req_stall = !adv_in;

   assign req_bus.stage_number = req_stage_number;
   assign req_bus.position     = req_position;

   // configuration register
   assign log2_size_in = csr_write_enable ? csr_write_data : log2_size_ff;

   // input register stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_req_in   = s1_req_ff;
      if (adv_in) begin
         s1_valid_in = req_valid;
         s1_req_in   = req_bus;
      end
   end

   fbpg_calc u_calc (
      .log2_size (log2_size_ff),
      .req       (s1_req_ff),
      .result    (calc_result)
   );

   // result register stage
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (adv_out) begin
         rsp_valid_in = s1_valid_ff;
         rsp_in       = calc_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_size_ff <= SIZE_W'(LOG2_MAX);
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         log2_size_ff <= log2_size_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_index_a = rsp_ff.read_index_a;
   assign rsp_read_index_b = rsp_ff.read_index_b;
   assign rsp_twiddle_real = rsp_ff.twiddle_real;
   assign rsp_twiddle_imag = rsp_ff.twiddle_imag;
   assign rsp_in_range     = rsp_ff.in_range;

   // checks
   assign rsp_live = rsp_valid_ff && rsp_ff.in_range;

   `FBPG_ASSERT_NXT(a_req_lands, clock, reset, req_valid && !req_stall, s1_valid_ff)
   `FBPG_ASSERT_IMP(a_out_of_range_zero, clock, reset, rsp_valid && !rsp_in_range, rsp_ff == '0)
   `FBPG_ASSERT_IMP(a_partners_differ, clock, reset, rsp_live, rsp_read_index_a != rsp_read_index_b)
   `FBPG_ASSERT_IMP(a_real_magnitude, clock, reset, rsp_live, rsp_twiddle_real != 16'sh8000)
   `FBPG_ASSERT_IMP(a_imag_magnitude, clock, reset, rsp_live, rsp_twiddle_imag != 16'sh8000)

endmodule

`default_nettype wire

>>> design/fbpg_calc.sv
// butterfly index pair and twiddle for one registered request
// depends on fbpg_pkg
`default_nettype none

module fbpg_calc
   import fbpg_pkg::*;
(
   input  wire logic [SIZE_W-1:0] log2_size,
   input  wire req_type           req,
   output result_type             result
);

   logic                  size_ok;
   logic                  stage_ok;
   logic                  pos_ok;
   logic [POS_W-1:0]      bit_mask;
   logic [POS_W-1:0]      lo_idx;
   logic [POS_W-1:0]      hi_idx;
   logic [POS_W-1:0]      k_val;
   logic [SIZE_W-1:0]     rev_shift;
   logic                  upper;
   logic [ARG_W-1:0]      t_val;
   logic [ARG_W-1:0]      q_val;
   logic [ARG_W-1:0]      cos_arg;
   logic [ARG_W-1:0]      sin_arg;
   logic                  cos_neg;
   logic [CW-1:0]         cos_mag;
   logic [CW-1:0]         sin_mag;
   logic signed [TW_W-1:0] cos_s;
   logic signed [TW_W-1:0] sin_s;

   // range checks against the configured size
   assign size_ok  = (log2_size != '0) && (log2_size <= SIZE_W'(LOG2_MAX));
   assign stage_ok = req.stage_number < log2_size;
   assign pos_ok   = {1'b0, req.position} < ((POS_W+1)'(1) << log2_size);

   // partner indices from the stage bit
   assign bit_mask  = POS_W'(1) << req.stage_number;
   assign lo_idx    = req.position & ~bit_mask;
   assign hi_idx    = lo_idx | bit_mask;
   assign k_val     = req.position & (bit_mask - POS_W'(1));
   assign upper     = |(req.position & bit_mask);
   assign rev_shift = SIZE_W'(POS_W) - log2_size;

   // twiddle angle in quarter-wave units, folded into the table range
   assign t_val = ARG_W'(k_val) << (STAGE_W'(LOG2_MAX + 1) - req.stage_number);
   assign q_val = ARG_W'(1) << LOG2_MAX;

   always_comb begin
      if (t_val <= q_val) begin
         cos_arg = t_val;
         sin_arg = q_val - t_val;
         cos_neg = 1'b0;
      end else begin
         cos_arg = (q_val << 1) - t_val;
         sin_arg = t_val - q_val;
         cos_neg = 1'b1;
      end
   end

   assign cos_mag = cos_lookup(TBL_IDX_W'(cos_arg >> TBL_STEP_LOG2));
   assign sin_mag = cos_lookup(TBL_IDX_W'(sin_arg >> TBL_STEP_LOG2));
   assign cos_s   = signed'(TW_W'(cos_mag));
   assign sin_s   = signed'(TW_W'(sin_mag));

   // assemble the result, zero when out of range
   always_comb begin
      result = '0;
      if (size_ok && stage_ok && pos_ok) begin
         if (req.stage_number == '0) begin
            result.read_index_a = rev_bits(lo_idx) >> rev_shift;
            result.read_index_b = rev_bits(hi_idx) >> rev_shift;
         end else begin
            result.read_index_a = lo_idx;
            result.read_index_b = hi_idx;
         end
         result.twiddle_real = (cos_neg ^ upper) ? -cos_s : cos_s;
         result.twiddle_imag = upper ? sin_s : -sin_s;
         result.in_range     = 1'b1;
      end
   end

endmodule

`default_nettype wire
